// File: hdl/jsp_pkg.sv
// Package with the shared constants and types of the five-point Jacobi stencil.
package jsp_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 16;
    localparam int GW_W      = 13;
    localparam int DATA_W    = 32;
    localparam int SUM_W     = DATA_W + 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

    localparam logic [GW_W-1:0]  GRID_WIDTH_RESET  = 13'd256;
    localparam logic [ROW_W-1:0] GRID_HEIGHT_RESET = 16'd256;

    // Position of the word being accepted and what it produces.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] rd_addr;
        logic             emit;
        logic             row_end;
        logic             frame_end;
    } pos_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     row_end;
        logic                     frame_end;
    } res_t;

endpackage

// File: hdl/jsp_if.sv
// Valid/ready channel interfaces for the grid input and the stencil result.
interface jsp_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [jsp_pkg::DATA_W-1:0]    sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface jsp_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [jsp_pkg::DATA_W-1:0]    value;
    logic                                 row_end;
    logic                                 frame_end;

    modport source (output valid, output value, output row_end, output frame_end, input ready);
    modport sink (input valid, input value, input row_end, input frame_end, output ready);
endinterface

// File: hdl/jsp_pos.sv
// Grid size registers and the column and row counters of the raster scan.
module jsp_pos
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [jsp_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [jsp_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            accept,
    output jsp_pkg::pos_t                   pos
);

    logic [jsp_pkg::GW_W-1:0]  grid_width_reg;
    logic [jsp_pkg::ROW_W-1:0] grid_height_reg;
    logic [jsp_pkg::COL_W-1:0] col_reg;
    logic [jsp_pkg::COL_W-1:0] col_next;
    logic [jsp_pkg::ROW_W-1:0] row_reg;
    logic [jsp_pkg::ROW_W-1:0] row_next;

    logic [jsp_pkg::GW_W-1:0]  w_eff;
    logic [jsp_pkg::COL_W-1:0] w_m1;
    logic [jsp_pkg::COL_W-1:0] w_m2;
    logic [jsp_pkg::ROW_W-1:0] h_m1;
    logic                      last_col;

    always_comb
    begin
        if (grid_width_reg < 13'd3)
        begin
            w_eff = 13'd3;
        end
        else if (grid_width_reg > 13'(jsp_pkg::MAX_WIDTH))
        begin
            w_eff = 13'(jsp_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = grid_width_reg;
        end
        w_m1 = jsp_pkg::COL_W'(w_eff - 13'd1);
        w_m2 = jsp_pkg::COL_W'(w_eff - 13'd2);
        h_m1 = (grid_height_reg < 16'd3) ? 16'd2 : grid_height_reg - 16'd1;
    end

    assign last_col = (col_reg == w_m1);

    always_comb
    begin
        pos.col       = col_reg;
        pos.emit      = (row_reg >= 16'd2) && (col_reg != '0) && (col_reg <= w_m2);
        pos.row_end   = (col_reg == w_m2);
        pos.frame_end = (col_reg == w_m2) && (row_reg == h_m1);
        if (col_reg == w_m2)
        begin
            pos.rd_addr = '0;
        end
        else if (last_col)
        begin
            pos.rd_addr = jsp_pkg::COL_W'(1);
        end
        else
        begin
            pos.rd_addr = col_reg + jsp_pkg::COL_W'(2);
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_we && (cfg_idx == jsp_pkg::REG_GRID_WIDTH || cfg_idx == jsp_pkg::REG_GRID_HEIGHT))
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = (row_reg == h_m1) ? '0 : row_reg + 16'd1;
            end
            else
            begin
                col_next = col_reg + jsp_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= jsp_pkg::GRID_WIDTH_RESET;
            grid_height_reg <= jsp_pkg::GRID_HEIGHT_RESET;
            col_reg         <= '0;
            row_reg         <= '0;
        end
        else
        begin
            if (cfg_we && cfg_idx == jsp_pkg::REG_GRID_WIDTH)
            begin
                grid_width_reg <= cfg_data[jsp_pkg::GW_W-1:0];
            end
            if (cfg_we && cfg_idx == jsp_pkg::REG_GRID_HEIGHT)
            begin
                grid_height_reg <= cfg_data;
            end
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n) col_reg <= w_m1)
        else $error("Column counter ran past the row width.");
    a_row_in_grid: assert property (@(posedge clk) disable iff (!rst_n) row_reg <= h_m1)
        else $error("Row counter ran past the grid height.");

endmodule

// File: hdl/jsp_window.sv
// Row store of the two rows above the current one and the neighbor window registers.
module jsp_window
(
    input  logic                                 clk,
    input  logic                                 accept,
    input  logic [jsp_pkg::COL_W-1:0]            col,
    input  logic [jsp_pkg::COL_W-1:0]            rd_addr,
    input  logic signed [jsp_pkg::DATA_W-1:0]    sample,
    output logic signed [jsp_pkg::DATA_W-1:0]    left,
    output logic signed [jsp_pkg::DATA_W-1:0]    right,
    output logic signed [jsp_pkg::DATA_W-1:0]    up
);

    // Each entry holds the column of row y-1 in the upper half and row y-2 in the lower half.
    logic [2*jsp_pkg::DATA_W-1:0] mem [jsp_pkg::MAX_WIDTH];
    logic [2*jsp_pkg::DATA_W-1:0] q_reg;
    logic [2*jsp_pkg::DATA_W-1:0] cur_reg;
    logic [jsp_pkg::DATA_W-1:0]   left_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[col] <= {sample, cur_reg[2*jsp_pkg::DATA_W-1:jsp_pkg::DATA_W]};
            q_reg    <= mem[rd_addr];
            cur_reg  <= q_reg;
            left_reg <= cur_reg[2*jsp_pkg::DATA_W-1:jsp_pkg::DATA_W];
        end
    end

    assign left  = $signed(left_reg);
    assign right = $signed(q_reg[2*jsp_pkg::DATA_W-1:jsp_pkg::DATA_W]);
    assign up    = $signed(cur_reg[jsp_pkg::DATA_W-1:0]);

endmodule

// File: hdl/jsp_out_skid.sv
// Output register with a skid stage for the stencil results.
module jsp_out_skid
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  jsp_pkg::res_t     res,
    output logic              space,
    jsp_out_if.source         out_ch
);

    logic          main_valid_reg;
    logic          skid_valid_reg;
    jsp_pkg::res_t main_reg;
    jsp_pkg::res_t skid_reg;
    logic          pop;

    assign space            = !skid_valid_reg;
    assign pop              = main_valid_reg && out_ch.ready;
    assign out_ch.valid     = main_valid_reg;
    assign out_ch.value     = main_reg.value;
    assign out_ch.row_end   = main_reg.row_end;
    assign out_ch.frame_end = main_reg.frame_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    main_valid_reg <= push;
                end
            end
            else if (push)
            begin
                if (main_valid_reg)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    main_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            main_reg <= skid_reg;
        end
        else if (push && (pop || !main_valid_reg))
        begin
            main_reg <= res;
        end
        else if (push)
        begin
            skid_reg <= res;
        end
    end

    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("Skid stage holds a word while the output register is empty.");
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("Result pushed while both output stages are full.");
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pop) |=> (main_valid_reg && !skid_valid_reg))
        else $error("Skid word lost on drain.");

endmodule

// File: hdl/jacobi_stencil_2d_five_point.sv
// Top level of the streaming five-point Jacobi stencil.
// The block takes a grid in raster order on in_ch, one Q16.16 sample per word,
// and gives on out_ch the mean of the four neighbors of every interior point.
// The result for point (x, y-1) is produced when sample (x, y) is accepted;
// border points give no word. row_end marks the last interior point of a row
// and frame_end the last interior point of the grid.
// The grid size is set through cfg_we, cfg_idx and cfg_data while the block is
// idle: index 0 is the width (3 to 4096), index 1 the height (at least 3).
// Any write restarts the frame at column zero of row zero.
// Throughput is one sample per cycle while the skid stage is empty: the row
// store reads and writes one entry per accepted word. Each result is registered
// as its sample is accepted. A skid stage holds one more result, so a stalled
// receiver blocks the input only when both stages are full.
// Reset clears the counters and the output stages, sets the size to 256 by 256,
// and leaves the row store contents undefined; every entry that a result uses
// is written earlier in the frame.
module jacobi_stencil_2d_five_point
(
    input  logic                            clk,
    input  logic                            rst_n,
    jsp_in_if.sink                          in_ch,
    jsp_out_if.source                       out_ch,
    input  logic                            cfg_we,
    input  logic [jsp_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [jsp_pkg::CFG_W-1:0]       cfg_data
);

    jsp_pkg::pos_t                        pos;
    jsp_pkg::res_t                        res;
    logic                                 accept;
    logic                                 space;
    logic signed [jsp_pkg::DATA_W-1:0]    left;
    logic signed [jsp_pkg::DATA_W-1:0]    right;
    logic signed [jsp_pkg::DATA_W-1:0]    up;
    logic signed [jsp_pkg::SUM_W-1:0]     sum;

    assign in_ch.ready = space;
    assign accept      = in_ch.valid && space;

    jsp_pos u_pos
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .accept   (accept),
        .pos      (pos)
    );

    jsp_window u_window
    (
        .clk     (clk),
        .accept  (accept),
        .col     (pos.col),
        .rd_addr (pos.rd_addr),
        .sample  (in_ch.sample),
        .left    (left),
        .right   (right),
        .up      (up)
    );

    // The arithmetic shift of the 34-bit sum rounds toward minus infinity.
    assign sum = jsp_pkg::SUM_W'(left) + jsp_pkg::SUM_W'(right)
               + jsp_pkg::SUM_W'(up) + jsp_pkg::SUM_W'(in_ch.sample);

    always_comb
    begin
        res.value     = sum[jsp_pkg::SUM_W-1:2];
        res.row_end   = pos.row_end;
        res.frame_end = pos.frame_end;
    end

    jsp_out_skid u_out_skid
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (accept && pos.emit),
        .res    (res),
        .space  (space),
        .out_ch (out_ch)
    );

    a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.frame_end) |-> out_ch.row_end)
        else $error("frame_end given on a point that does not end its row.");

endmodule
